@@ rtl/core/tcw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and command/status types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLS   = 80;
    localparam int DEF_ROWS   = 25;

    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int ADDR_W     = 11;
    // Wide enough for row*COLS+col over the whole parameter range.
    localparam int PROD_W     = 12;
    localparam int NUM_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CONV_CNT_W = $clog2(NUM_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [1:0] OP_CHAR    = 2'd0;
    localparam logic [1:0] OP_NUM_FIX = 2'd1;
    localparam logic [1:0] OP_NUM_MIN = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] SEL_CHAR    = 2'd0;
    localparam logic [1:0] SEL_DIGIT   = 2'd1;
    localparam logic [1:0] SEL_NEWLINE = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] DIGIT_ZERO   = 8'd48;
    localparam logic [7:0] NUM_COLOUR   = 8'd15;

    typedef struct packed {
        logic       load;       // capture the accepted item
        logic       conv_step;  // one binary-to-decimal shift step
        logic       skip;       // drop a leading zero digit
        logic       emit;       // produce one result
        logic [1:0] sel;        // source of the emitted character
        logic       last;       // final result of the item
    } cmd_t;

    typedef struct packed {
        logic slot_free;        // output register can take a result
        logic msd_zero;         // leading decimal digit is zero
    } status_t;

endpackage
`default_nettype wire

@@ rtl/core/tcw_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: accepts items, runs the decimal conversion and orders the results.
// ----------------------------------------------------------------------------
module tcw_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        operation,
    output tcw_pkg::cmd_t          cmd,
    input  wire tcw_pkg::status_t  st
);
    import tcw_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHAR  = 3'd1;
    localparam logic [2:0] S_CONV  = 3'd2;
    localparam logic [2:0] S_SKIP  = 3'd3;
    localparam logic [2:0] S_DIGIT = 3'd4;
    localparam logic [2:0] S_NEWLN = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CONV_CNT_W-1:0] conv_cnt_reg, conv_cnt_next;
    logic [DIG_CNT_W-1:0]  dig_cnt_reg, dig_cnt_next;
    logic                  min_reg, min_next;
    logic                  accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        conv_cnt_next = conv_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        min_next      = min_reg;
        cmd           = '0;
        cmd.sel       = SEL_CHAR;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load      = 1'b1;
                    conv_cnt_next = '0;
                    dig_cnt_next  = DIG_CNT_W'(NUM_DIGITS);
                    min_next      = (operation == OP_NUM_MIN);
                    case (operation)
                        OP_CHAR:    state_next = S_CHAR;
                        OP_NUM_FIX: state_next = S_CONV;
                        OP_NUM_MIN: state_next = S_CONV;
                        OP_UNUSED:  state_next = S_IDLE;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_CHAR:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_CHAR;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
                conv_cnt_next = conv_cnt_reg + 1'b1;
                if (conv_cnt_reg == CONV_CNT_W'(NUM_W - 1))
                begin
                    state_next = min_reg ? S_SKIP : S_DIGIT;
                end
            end
            S_SKIP:
            begin
                // The last digit is always printed, so zero comes out as '0'.
                if (st.msd_zero && (dig_cnt_reg > DIG_CNT_W'(1)))
                begin
                    cmd.skip     = 1'b1;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (st.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.sel      = SEL_DIGIT;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DIG_CNT_W'(1))
                    begin
                        state_next = S_NEWLN;
                    end
                end
            end
            S_NEWLN:
            begin
                if (st.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_NEWLINE;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        conv_cnt_reg <= conv_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        min_reg      <= min_next;
    end

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.slot_free)
        else $error("result emitted while the output register is occupied");

    a_number_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation == OP_NUM_FIX || operation == OP_NUM_MIN))
        |=> (state_reg == S_CONV && conv_cnt_reg == '0))
        else $error("number item did not start the conversion");

    a_skip_only_minimal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.skip |-> (min_reg && dig_cnt_reg > DIG_CNT_W'(1)))
        else $error("digit dropped outside minimal form");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == S_IDLE))
        else $error("item did not end after its final result");

endmodule
`default_nettype wire

@@ rtl/core/tcw_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: cursor, shift-add-3 decimal converter and the output register.
// ----------------------------------------------------------------------------
module tcw_dp
#(
    parameter int COLS = tcw_pkg::DEF_COLS,
    parameter int ROWS = tcw_pkg::DEF_ROWS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [7:0]                 char_code,
    input  wire logic [7:0]                 attribute,
    input  wire logic [tcw_pkg::NUM_W-1:0]  number,
    input  wire tcw_pkg::cmd_t              cmd,
    output tcw_pkg::status_t                st,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            write_valid,
    output logic [tcw_pkg::ADDR_W-1:0]      cell_address,
    output logic [15:0]                     cell_word,
    output logic                            off_screen,
    output logic                            last
);
    import tcw_pkg::*;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [7:0]        char_reg, char_next;
    logic [7:0]        attr_reg, attr_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [BCD_W-1:0]  bcd_adj;

    logic              ov_reg, ov_next;
    logic              wv_reg, wv_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [15:0]       word_reg, word_next;
    logic              off_reg, off_next;
    logic              last_reg, last_next;

    logic [7:0]        em_char;
    logic [7:0]        em_attr;
    logic              off_now;
    logic [COL_W:0]    col_inc;
    logic [PROD_W-1:0] lin_addr;
    logic [ROW_W-1:0]  row_adv;
    logic [3:0]        msd;

    assign msd          = bcd_reg[BCD_W-1 -: 4];
    assign st.slot_free = !ov_reg || out_ready;
    assign st.msd_zero  = (msd == 4'd0);

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_CHAR:
            begin
                em_char = char_reg;
                em_attr = attr_reg;
            end
            SEL_DIGIT:
            begin
                em_char = DIGIT_ZERO + {4'd0, msd};
                em_attr = NUM_COLOUR;
            end
            SEL_NEWLINE:
            begin
                em_char = NEWLINE_CODE;
                em_attr = NUM_COLOUR;
            end
            default:
            begin
                em_char = NEWLINE_CODE;
                em_attr = NUM_COLOUR;
            end
        endcase
    end

    assign off_now  = (row_reg >= ROW_W'(ROWS));
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign lin_addr = PROD_W'(row_reg) * PROD_W'(COLS) + PROD_W'(col_reg);
    // The row stops at ROWS once the cursor has left the screen.
    assign row_adv  = off_now ? ROW_W'(ROWS) : row_reg + 1'b1;

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        char_next = char_reg;
        attr_next = attr_reg;
        num_next  = num_reg;
        bcd_next  = bcd_reg;
        ov_next   = ov_reg;
        wv_next   = wv_reg;
        addr_next = addr_reg;
        word_next = word_reg;
        off_next  = off_reg;
        last_next = last_reg;

        if (cmd.load)
        begin
            char_next = char_code;
            attr_next = attribute;
            num_next  = number;
            bcd_next  = '0;
        end
        else if (cmd.conv_step)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], num_reg[NUM_W-1]};
            num_next = {num_reg[NUM_W-2:0], 1'b0};
        end
        else if (cmd.skip)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
        end

        if (out_ready)
        begin
            ov_next = 1'b0;
        end

        if (cmd.emit)
        begin
            ov_next   = 1'b1;
            last_next = cmd.last;
            off_next  = off_now;
            wv_next   = 1'b0;
            addr_next = '0;
            word_next = '0;
            if (cmd.sel == SEL_DIGIT)
            begin
                bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
            end
            if (em_char == NEWLINE_CODE)
            begin
                row_next = row_adv;
                col_next = '0;
            end
            else
            begin
                if (!off_now)
                begin
                    wv_next   = 1'b1;
                    addr_next = lin_addr[ADDR_W-1:0];
                    word_next = {em_attr, em_char};
                end
                if (col_inc >= (COL_W+1)'(COLS))
                begin
                    row_next = row_adv;
                    col_next = '0;
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        attr_reg <= attr_next;
        num_reg  <= num_next;
        bcd_reg  <= bcd_next;
        wv_reg   <= wv_next;
        addr_reg <= addr_next;
        word_reg <= word_next;
        off_reg  <= off_next;
        last_reg <= last_next;
    end

    assign out_valid    = ov_reg;
    assign write_valid  = wv_reg;
    assign cell_address = addr_reg;
    assign cell_word    = word_reg;
    assign off_screen   = off_reg;
    assign last         = last_reg;

    a_no_write_off_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && wv_reg) |-> !off_reg)
        else $error("cell write flagged off screen");

    a_row_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_W'(ROWS))
        else $error("cursor row past the saturation point");

    a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (COL_W+1)'(col_reg) < (COL_W+1)'(COLS))
        else $error("cursor column past the line end");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> (ov_reg && $stable(word_reg) && $stable(last_reg)))
        else $error("stalled result changed");

endmodule
`default_nettype wire

@@ rtl/core/text_console_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Text console writer with a row/column cursor and decimal number printing.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   operation, char_code, attribute, number
//  out      out_valid / out_ready write_valid, cell_address, cell_word,
//                                 off_screen, last
//
//  A character item is accepted, then gives one result.
//  A number item is accepted and then runs 32 steps of the bit-serial
//  shift-add-3 converter; the minimal form then drops leading zeros one at
//  a time until it finds the first printed digit, and each result then
//  passes through the single output register.
//  A new item is accepted only once the previous one has issued all results.
//  Reset clears the cursor to row 0, column 0 and empties the output register.
//  A low out_ready holds the pending result and stalls the next result until it is taken.
// ----------------------------------------------------------------------------
module text_console_writer
#(
    parameter int COLS = tcw_pkg::DEF_COLS,
    parameter int ROWS = tcw_pkg::DEF_ROWS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 operation,
    input  wire logic [7:0]                 char_code,
    input  wire logic [7:0]                 attribute,
    input  wire logic [tcw_pkg::NUM_W-1:0]  number,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            write_valid,
    output logic [tcw_pkg::ADDR_W-1:0]      cell_address,
    output logic [15:0]                     cell_word,
    output logic                            off_screen,
    output logic                            last
);
    import tcw_pkg::*;

    cmd_t    cmd;
    status_t st;

    tcw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .cmd       (cmd),
        .st        (st)
    );

    tcw_dp
    #(
        .COLS (COLS),
        .ROWS (ROWS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_code    (char_code),
        .attribute    (attribute),
        .number       (number),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_valid  (write_valid),
        .cell_address (cell_address),
        .cell_word    (cell_word),
        .off_screen   (off_screen),
        .last         (last)
    );

endmodule
`default_nettype wire
